### hw/rtl/f32asmd_pkg.sv
// Shared types, constants and packing helpers of the single-precision arithmetic unit.
package f32asmd_pkg;

    localparam int EXP_W       = 8;
    localparam int FRAC_W      = 23;
    localparam int MANT_W      = FRAC_W + 1;
    localparam int EXPI_W      = EXP_W + 2;
    localparam int QUOT_BITS   = MANT_W;
    localparam int STEP_W      = $clog2(QUOT_BITS);
    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [EXPI_W-1:0] EXP_BIAS = EXPI_W'(127);
    localparam logic signed [EXPI_W-1:0] EXP_SAT  = EXPI_W'(255);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        K_ADD  = 3'd0,
        K_SUB  = 3'd1,
        K_ZERO = 3'd2,
        K_MUL  = 3'd3,
        K_DIV  = 3'd4
    } kind_t;

    // For add/subtract: exp_a is the larger exponent, man_a the mantissa of the larger
    // magnitude, man_b the aligned mantissa of the smaller one.
    typedef struct packed {
        kind_t             kind;
        logic              sign;
        logic [EXP_W-1:0]  exp_a;
        logic [EXP_W-1:0]  exp_b;
        logic [MANT_W-1:0] man_a;
        logic [MANT_W-1:0] man_b;
    } job_t;

    function automatic logic [31:0] pack(input logic sign, input logic [EXP_W-1:0] e,
                                         input logic [FRAC_W-1:0] f);
        return {sign, e, f};
    endfunction

    function automatic logic [31:0] infinity_of(input logic sign);
        return {sign, {EXP_W{1'b1}}, {FRAC_W{1'b0}}};
    endfunction

endpackage

### hw/rtl/f32asmd_queue.sv
// Short job queue between the classifying front and the execution back.
module f32asmd_queue #(
    parameter int DEPTH = f32asmd_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  f32asmd_pkg::job_t  push_job,
    input  logic               pop,
    output f32asmd_pkg::job_t  head_job,
    output logic               empty,
    output logic               full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    f32asmd_pkg::job_t store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign head_job = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### hw/rtl/f32asmd_front.sv
// Front end: unpacks operands, decodes the operation and aligns add/subtract mantissas.
module f32asmd_front (
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         action,
    input  logic [31:0]        operand_a,
    input  logic [31:0]        operand_b,
    output logic               push,
    output f32asmd_pkg::job_t  push_job
);

    localparam int EW = f32asmd_pkg::EXP_W;
    localparam int MW = f32asmd_pkg::MANT_W;
    localparam int FW = f32asmd_pkg::FRAC_W;

    logic [EW-1:0] exp_a, exp_b, exp_big, exp_small, shift;
    logic [MW-1:0] man_a, man_b, man_big, man_small, man_aligned;
    logic          sign_b_eff, b_bigger, sign_big;

    assign push  = start && !busy;
    assign exp_a = operand_a[FW +: EW];
    assign exp_b = operand_b[FW +: EW];
    assign man_a = {1'b1, operand_a[FW-1:0]};
    assign man_b = {1'b1, operand_b[FW-1:0]};

    always_comb
    begin
        sign_b_eff  = operand_b[31] ^ (action == f32asmd_pkg::OP_SUB);
        b_bigger    = (operand_b[30:0] > operand_a[30:0]);
        exp_big     = b_bigger ? exp_b : exp_a;
        exp_small   = b_bigger ? exp_a : exp_b;
        man_big     = b_bigger ? man_b : man_a;
        man_small   = b_bigger ? man_a : man_b;
        sign_big    = b_bigger ? sign_b_eff : operand_a[31];
        shift       = exp_big - exp_small;
        man_aligned = (shift >= EW'(MW)) ? '0 : (man_small >> shift[4:0]);

        push_job.exp_a = exp_a;
        push_job.exp_b = exp_b;
        push_job.man_a = man_a;
        push_job.man_b = man_b;
        push_job.sign  = operand_a[31] ^ operand_b[31];
        unique case (f32asmd_pkg::op_t'(action))
            f32asmd_pkg::OP_MUL:
            begin
                push_job.kind = f32asmd_pkg::K_MUL;
            end
            f32asmd_pkg::OP_DIV:
            begin
                push_job.kind = f32asmd_pkg::K_DIV;
            end
            default:
            begin
                push_job.sign  = sign_big;
                push_job.exp_a = exp_big;
                push_job.man_a = man_big;
                push_job.man_b = man_aligned;
                if (operand_a[31] == sign_b_eff)
                begin
                    push_job.kind = f32asmd_pkg::K_ADD;
                end
                else if (operand_a[30:0] == operand_b[30:0])
                begin
                    push_job.kind = f32asmd_pkg::K_ZERO;
                end
                else
                begin
                    push_job.kind = f32asmd_pkg::K_SUB;
                end
            end
        endcase
    end

endmodule

### hw/rtl/f32asmd_back.sv
// Back end: executes queued jobs with a shared sequencer and drives the result beat.
module f32asmd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  f32asmd_pkg::job_t  head_job,
    input  logic               empty,
    output logic               pop,
    output logic [31:0]        result_bits,
    output logic               done
);

    localparam int EW = f32asmd_pkg::EXP_W;
    localparam int MW = f32asmd_pkg::MANT_W;
    localparam int FW = f32asmd_pkg::FRAC_W;
    localparam int IW = f32asmd_pkg::EXPI_W;
    localparam int SW = f32asmd_pkg::STEP_W;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_ADD  = 6'b000010,
        ST_NORM = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_DFIN = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic                 sign_reg, sign_next;
    logic signed [IW-1:0] exp_reg, exp_next;
    logic [MW:0]          man_reg, man_next;
    logic [2*MW-1:0]      prod_reg, prod_next;
    logic [MW:0]          rem_reg, rem_next;
    logic [MW-1:0]        dvsr_reg, dvsr_next;
    logic [SW-1:0]        step_reg, step_next;
    logic [31:0]          result_reg, result_next;
    logic                 done_reg, done_next;

    logic [31:0]          add_res, norm_res, mul_res, div_res;
    logic                 norm_busy;

    // Sum finish: absorb the carry out.
    always_comb
    begin
        logic signed [IW-1:0] e2;
        logic [MW-1:0]        m2;
        e2 = exp_reg + IW'(man_reg[MW]);
        m2 = man_reg[MW] ? man_reg[MW:1] : man_reg[MW-1:0];
        add_res = (e2 >= f32asmd_pkg::EXP_SAT) ? f32asmd_pkg::infinity_of(sign_reg)
                : f32asmd_pkg::pack(sign_reg, e2[EW-1:0], m2[FW-1:0]);
    end

    // Difference: one left shift per cycle until normalized or exponent hits zero.
    always_comb
    begin
        logic [MW-1:0] m2;
        norm_busy = !man_reg[MW-1] && (exp_reg != '0);
        m2 = (exp_reg == '0) ? (man_reg[MW-1:0] >> 1) : man_reg[MW-1:0];
        norm_res = f32asmd_pkg::pack(sign_reg, exp_reg[EW-1:0], m2[FW-1:0]);
    end

    always_comb
    begin
        logic [MW:0]          m1;
        logic [MW-1:0]        m2;
        logic signed [IW-1:0] e2;
        m1 = prod_reg[FW +: MW + 1];
        e2 = exp_reg + IW'(m1[MW]);
        m2 = m1[MW] ? m1[MW:1] : m1[MW-1:0];
        if (e2 >= f32asmd_pkg::EXP_SAT)
        begin
            mul_res = f32asmd_pkg::infinity_of(sign_reg);
        end
        else if (e2 < 0)
        begin
            mul_res = {sign_reg, 31'd0};
        end
        else
        begin
            mul_res = f32asmd_pkg::pack(sign_reg, e2[EW-1:0], m2[FW-1:0]);
        end
    end

    // Quotient finish: at most one normalizing shift, then denormalize on underflow.
    always_comb
    begin
        logic [MW-1:0]        q1, q2;
        logic signed [IW-1:0] e1, e2;
        logic [IW-1:0]        sh;
        if (!man_reg[MW-1] && (exp_reg > 0))
        begin
            q1 = {man_reg[MW-2:0], 1'b0};
            e1 = exp_reg - 1'b1;
        end
        else
        begin
            q1 = man_reg[MW-1:0];
            e1 = exp_reg;
        end
        sh = IW'(1) - e1;
        q2 = q1;
        e2 = e1;
        if (e1 <= 0)
        begin
            q2 = (sh >= IW'(MW)) ? '0 : (q1 >> sh[4:0]);
            e2 = '0;
        end
        div_res = (e2 >= f32asmd_pkg::EXP_SAT) ? f32asmd_pkg::infinity_of(sign_reg)
                : f32asmd_pkg::pack(sign_reg, e2[EW-1:0], q2[FW-1:0]);
    end

    always_comb
    begin
        logic          ge;
        logic [MW:0]   diff;
        state_next  = state_reg;
        sign_next   = sign_reg;
        exp_next    = exp_reg;
        man_next    = man_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        dvsr_next   = dvsr_reg;
        step_next   = step_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        pop         = 1'b0;
        ge          = (rem_reg >= {1'b0, dvsr_reg});
        diff        = rem_reg - {1'b0, dvsr_reg};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop       = 1'b1;
                    sign_next = head_job.sign;
                    case (head_job.kind)
                        f32asmd_pkg::K_ADD:
                        begin
                            man_next   = {1'b0, head_job.man_a} + {1'b0, head_job.man_b};
                            exp_next   = IW'(head_job.exp_a);
                            state_next = ST_ADD;
                        end
                        f32asmd_pkg::K_SUB:
                        begin
                            man_next   = {1'b0, head_job.man_a} - {1'b0, head_job.man_b};
                            exp_next   = IW'(head_job.exp_a);
                            state_next = ST_NORM;
                        end
                        f32asmd_pkg::K_MUL:
                        begin
                            prod_next  = head_job.man_a * head_job.man_b;
                            exp_next   = IW'(head_job.exp_a) + IW'(head_job.exp_b)
                                       - f32asmd_pkg::EXP_BIAS;
                            state_next = ST_MUL;
                        end
                        f32asmd_pkg::K_DIV:
                        begin
                            rem_next   = {1'b0, head_job.man_a};
                            dvsr_next  = head_job.man_b;
                            man_next   = '0;
                            step_next  = SW'(f32asmd_pkg::QUOT_BITS - 1);
                            exp_next   = IW'(head_job.exp_a) - IW'(head_job.exp_b)
                                       + f32asmd_pkg::EXP_BIAS;
                            state_next = ST_DIV;
                        end
                        default:
                        begin
                            result_next = '0;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end
            ST_ADD:
            begin
                result_next = add_res;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_NORM:
            begin
                if (norm_busy)
                begin
                    man_next = {man_reg[MW-1:0], 1'b0};
                    exp_next = exp_reg - 1'b1;
                end
                else
                begin
                    result_next = norm_res;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                result_next = mul_res;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_DIV:
            begin
                // Restoring step: one quotient bit per cycle.
                man_next  = {man_reg[MW-1:0], ge};
                rem_next  = ge ? {diff[MW-1:0], 1'b0} : {rem_reg[MW-1:0], 1'b0};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_DFIN;
                end
            end
            ST_DFIN:
            begin
                result_next = div_res;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sign_reg   <= sign_next;
        exp_reg    <= exp_next;
        man_reg    <= man_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        dvsr_reg   <= dvsr_next;
        result_reg <= result_next;
    end

    assign result_bits = result_reg;
    assign done        = done_reg;

endmodule

### hw/rtl/float32_add_sub_mul_div_unit.sv
// Top level of the truncating single-precision add/subtract/multiply/divide unit.
// An operation is taken on a clock edge where start is high and busy is low; busy
// is high only while the job queue is full. Each result appears on result_bits for
// exactly one cycle with done high, and must be taken then: the unit cannot be
// stalled. An accepted operation may wait in the queue before the sequencer runs it:
// add and multiply pass through a finishing state, equal-magnitude cancellation
// finishes from idle, subtract shifts left once per cycle until normalized or its
// exponent is zero, and divide takes one quotient bit per cycle in the restoring
// divider before a finishing state. The execution sequencer handles one job at a
// time, so it pops a new job from the queue only after the last one is done.
module float32_add_sub_mul_div_unit #(
    parameter int QUEUE_DEPTH = f32asmd_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic [31:0] result_bits,
    output logic        done
);

    f32asmd_pkg::job_t push_job, head_job;
    logic              push, pop, empty, full;

    assign busy = full;

    f32asmd_front u_front (
        .start     (start),
        .busy      (busy),
        .action    (action),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .push      (push),
        .push_job  (push_job)
    );

    f32asmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (empty),
        .full     (full)
    );

    f32asmd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_job    (head_job),
        .empty       (empty),
        .pop         (pop),
        .result_bits (result_bits),
        .done        (done)
    );

`ifndef SYNTH
    // The queue fills only through an accepted beat.
    assert property (@(posedge clk) disable iff (!rst_n) $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted beat");

    // A pop never comes from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("pop from empty queue");
`endif

endmodule

### bench/testbench.sv
// Self-checking testbench of the truncating single-precision add/subtract/multiply/divide unit.
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] result_bits;
    logic        done;

    logic [31:0] expected_results[$];
    int          error_count;
    int          beats_sent;
    int          results_seen;
    int          idle_cycles;
    int          send_gap_pct;
    logic [3:0]  ops_seen;

    float32_add_sub_mul_div_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .operand_a(operand_a), .operand_b(operand_b), .result_bits(result_bits),
        .done(done)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic [31:0] fp_pack(input logic s, input logic [31:0] e,
                                            input logic [31:0] m);
        return {s, e[7:0], m[22:0]};
    endfunction

    function automatic logic [31:0] sum_of(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] big;
        logic [31:0] lit;
        logic [31:0] e;
        logic [31:0] mb;
        logic [31:0] ms;
        logic [31:0] sh;
        logic [31:0] r;
        big = a;
        lit = b;
        if (b[30:0] > a[30:0])
        begin
            big = b;
            lit = a;
        end
        e  = {24'd0, big[30:23]};
        mb = {8'd0, 1'b1, big[22:0]};
        ms = {8'd0, 1'b1, lit[22:0]};
        sh = e - {24'd0, lit[30:23]};
        ms = (sh >= 32) ? 32'd0 : (ms >> sh);
        if (a[31] == b[31])
        begin
            r = mb + ms;
            if (r > 32'h00FF_FFFF)
            begin
                r = r >> 1;
                e = e + 1;
            end
            if (e >= 255)
                return f32asmd_pkg::infinity_of(big[31]);
            return fp_pack(big[31], e, r);
        end
        if (a[30:0] == b[30:0])
            return 32'd0;
        r = mb - ms;
        while (r < 32'h0080_0000 && e > 0)
        begin
            r = r << 1;
            e = e - 1;
        end
        if (e == 0)
            r = r >> 1;
        return fp_pack(big[31], e, r);
    endfunction

    function automatic logic [31:0] product_of(input logic [31:0] a, input logic [31:0] b);
        logic        s;
        logic [63:0] p;
        logic [31:0] m;
        int          e;
        s = a[31] ^ b[31];
        p = {40'd0, 1'b1, a[22:0]} * {40'd0, 1'b1, b[22:0]};
        m = p[54:23];
        e = int'(a[30:23]) + int'(b[30:23]) - 127;
        while (m > 32'h00FF_FFFF)
        begin
            m = m >> 1;
            e = e + 1;
        end
        if (e >= 255)
            return f32asmd_pkg::infinity_of(s);
        if (e < 0)
            return {s, 31'd0};
        return fp_pack(s, e, m);
    endfunction

    function automatic logic [31:0] quotient_of(input logic [31:0] a, input logic [31:0] b);
        logic        s;
        logic [63:0] q;
        int          e;
        int          sh;
        s = a[31] ^ b[31];
        q = ({40'd0, 1'b1, a[22:0]} << 23) / {40'd0, 1'b1, b[22:0]};
        e = int'(a[30:23]) - int'(b[30:23]) + 127;
        while (q[23] == 1'b0 && e > 0)
        begin
            q = q << 1;
            e = e - 1;
        end
        if (e <= 0)
        begin
            sh = 1 - e;
            q = (sh >= 64) ? 64'd0 : (q >> sh);
            e = 0;
        end
        if (e >= 255)
            return f32asmd_pkg::infinity_of(s);
        return fp_pack(s, e, q[31:0]);
    endfunction

    function automatic logic [31:0] fpu_result(input f32asmd_pkg::op_t op,
                                               input logic [31:0] a,
                                               input logic [31:0] b);
        case (op)
            f32asmd_pkg::OP_ADD: return sum_of(a, b);
            f32asmd_pkg::OP_SUB: return sum_of(a, b ^ 32'h8000_0000);
            f32asmd_pkg::OP_MUL: return product_of(a, b);
            default:             return quotient_of(a, b);
        endcase
    endfunction

    // Hold one beat until the unit takes it, then queue its expected result.
    task automatic send_beat(input f32asmd_pkg::op_t op, input logic [31:0] a,
                             input logic [31:0] b);
        while ($urandom_range(99) < send_gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        action    <= op;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.push_back(fpu_result(op, a, b));
        ops_seen[op] = 1'b1;
        beats_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] random_operand();
        logic [31:0] x;
        x = $urandom;
        case ($urandom_range(5))
            0: x[30:23] = 8'($urandom_range(120, 134));
            1: x[30:23] = 8'($urandom_range(0, 3));
            2: x[30:23] = 8'($urandom_range(250, 255));
            3: x[30:23] = 8'd127;
            default: ;
        endcase
        return x;
    endfunction

    task automatic test_directed();
        send_beat(f32asmd_pkg::OP_ADD, 32'h3F80_0000, 32'h3F80_0000);
        send_beat(f32asmd_pkg::OP_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
        send_beat(f32asmd_pkg::OP_ADD, 32'h3F80_0000, 32'h0000_0001);
        send_beat(f32asmd_pkg::OP_ADD, 32'h4000_0000, 32'hC000_0000);
        send_beat(f32asmd_pkg::OP_ADD, 32'hC040_0000, 32'h3F80_0000);
        send_beat(f32asmd_pkg::OP_SUB, 32'h3F80_0000, 32'h3F80_0000);
        send_beat(f32asmd_pkg::OP_SUB, 32'h3F80_0001, 32'h3F80_0000);
        send_beat(f32asmd_pkg::OP_SUB, 32'h0080_0000, 32'h0000_0001);
        send_beat(f32asmd_pkg::OP_SUB, 32'h0000_0000, 32'hFFFF_FFFF);
        send_beat(f32asmd_pkg::OP_SUB, 32'h7F80_0000, 32'h0000_0000);
        send_beat(f32asmd_pkg::OP_MUL, 32'h3FC0_0000, 32'hC000_0000);
        send_beat(f32asmd_pkg::OP_MUL, 32'h7F7F_FFFF, 32'h4000_0000);
        send_beat(f32asmd_pkg::OP_MUL, 32'h0000_0000, 32'h8000_0000);
        send_beat(f32asmd_pkg::OP_MUL, 32'h3F00_0000, 32'h0080_0000);
        send_beat(f32asmd_pkg::OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(f32asmd_pkg::OP_DIV, 32'h3F80_0000, 32'h4040_0000);
        send_beat(f32asmd_pkg::OP_DIV, 32'h7F7F_FFFF, 32'h0000_0000);
        send_beat(f32asmd_pkg::OP_DIV, 32'h0080_0000, 32'h4000_0000);
        send_beat(f32asmd_pkg::OP_DIV, 32'h0000_0000, 32'h7F7F_FFFF);
        send_beat(f32asmd_pkg::OP_DIV, 32'hBF80_0000, 32'h3FFF_FFFF);
        send_beat(f32asmd_pkg::OP_DIV, 32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    task automatic test_random(input int count);
        logic [31:0] a;
        logic [31:0] b;
        for (int i = 0; i < count; i++)
        begin
            a = random_operand();
            b = random_operand();
            // Steer some operand pairs close together, for deep cancellation in add/sub.
            if ($urandom_range(7) == 0)
                b = {1'($urandom_range(1)), a[30:4], 4'($urandom)};
            send_beat(f32asmd_pkg::op_t'($urandom_range(3)), a, b);
        end
    endtask

    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result_bits);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_bits !== want)
                begin
                    $display("%0t: result_bits expected %h actual %h", $time, want,
                             result_bits);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        action = f32asmd_pkg::OP_ADD;
        operand_a = '0;
        operand_b = '0;
        error_count = 0;
        beats_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        ops_seen = '0;
        send_gap_pct = 13;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        wait_drained();
        test_random(380);
        send_gap_pct = 83;
        test_random(380);
        wait_drained();
        send_gap_pct = 0;
        test_random(380);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d beats, checked %0d results, operations covered %b.",
                 beats_sent, results_seen, ops_seen);
        if (error_count == 0 && expected_results.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
